// ===== rtl/yenc_body_decoder_assert.svh =====
// ----------------------------------------------------------------------------
// yEnc body decoder assertion macros
// Concurrent checks on the clock and reset of the including module.
// ----------------------------------------------------------------------------
`ifndef YENC_BODY_DECODER_ASSERT_SVH
`define YENC_BODY_DECODER_ASSERT_SVH

// condition must hold in the same cycle as the trigger
`define YBD_ASSERT_SAME(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |-> (cond)) \
        else $error("yenc_body_decoder: same-cycle check failed");

// condition must hold in the cycle after the trigger
`define YBD_ASSERT_NEXT(lbl, clk, rst_n, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (trig) |=> (cond)) \
        else $error("yenc_body_decoder: next-cycle check failed");

`endif

// ===== rtl/ybd_pkg.sv =====
// ----------------------------------------------------------------------------
// ybd_pkg
// Types and constants shared by the yEnc body decoder modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ybd_pkg;

    localparam int SIZE_W = 31;
    localparam int LINE_W = 10;
    localparam int CFG_IDX_W = 1;

    localparam logic [LINE_W-1:0] LINE_MAX = {LINE_W{1'b1}};
    localparam logic [LINE_W-1:0] LINE_LEN_RESET = 10'd128;

    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_EXPECTED_LINE_LENGTH = 1'b1;

    localparam logic [7:0] PLAIN_OFFSET = 8'd42;
    localparam logic [7:0] ESCAPE_OFFSET = 8'd106;
    localparam logic [7:0] CH_ESC = 8'h3D;
    localparam logic [7:0] CH_Y = 8'h79;
    localparam logic [7:0] CH_CR = 8'h0D;
    localparam logic [7:0] CH_LF = 8'h0A;

    typedef enum logic [2:0] {
        ST_RUNNING  = 3'd0,
        ST_END_OK   = 3'd1,
        ST_SIZE_BAD = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_BAD_LINE = 3'd4,
        ST_TRUNC    = 3'd5
    } t_status;

    typedef enum logic [1:0] {
        CLS_DATA = 2'd0,
        CLS_CR   = 2'd1,
        CLS_LF   = 2'd2,
        CLS_ESC  = 2'd3
    } t_cls;

    typedef struct packed {
        t_cls       cls;
        logic       is_y;
        logic [7:0] plain_val;
        logic [7:0] esc_val;
        logic       first;
        logic       last;
    } t_cmd;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_valid;
        t_status    status;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/yenc_in_if.sv =====
// ----------------------------------------------------------------------------
// yenc_in_if
// Raw byte channel into the yEnc body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface yenc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_message;
    logic       last_of_data;

    modport source (output valid, output in_byte, output first_of_message,
                    output last_of_data, input ready);
    modport sink (input valid, input in_byte, input first_of_message,
                  input last_of_data, output ready);
endinterface

`default_nettype wire

// ===== rtl/yenc_out_if.sv =====
// ----------------------------------------------------------------------------
// yenc_out_if
// Decoded result channel out of the yEnc body decoder.
// ----------------------------------------------------------------------------
`default_nettype none

interface yenc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic [2:0] status;

    modport source (output valid, output out_byte, output out_valid,
                    output status, input ready);
    modport sink (input valid, input out_byte, input out_valid,
                  input status, output ready);
endinterface

`default_nettype wire

// ===== rtl/ybd_front.sv =====
// ----------------------------------------------------------------------------
// ybd_front
// Accepts raw bytes, classifies them and precomputes both decoded values.
// ----------------------------------------------------------------------------
`default_nettype none

module ybd_front (
    yenc_in_if.sink         i_in_ch,
    input  wire logic       i_q_full,
    output ybd_pkg::t_cmd   o_cmd,
    output logic            o_push
);

    ybd_pkg::t_cls w_cls;

    always_comb begin
        unique case (i_in_ch.in_byte)
            ybd_pkg::CH_CR:  w_cls = ybd_pkg::CLS_CR;
            ybd_pkg::CH_LF:  w_cls = ybd_pkg::CLS_LF;
            ybd_pkg::CH_ESC: w_cls = ybd_pkg::CLS_ESC;
            default:         w_cls = ybd_pkg::CLS_DATA;
        endcase
    end

    assign i_in_ch.ready = !i_q_full;
    assign o_push        = i_in_ch.valid && !i_q_full;

    always_comb begin
        o_cmd.cls       = w_cls;
        o_cmd.is_y      = (i_in_ch.in_byte == ybd_pkg::CH_Y);
        o_cmd.plain_val = i_in_ch.in_byte - ybd_pkg::PLAIN_OFFSET;
        o_cmd.esc_val   = i_in_ch.in_byte - ybd_pkg::ESCAPE_OFFSET;
        o_cmd.first     = i_in_ch.first_of_message;
        o_cmd.last      = i_in_ch.last_of_data;
    end

endmodule

`default_nettype wire

// ===== rtl/ybd_queue.sv =====
// ----------------------------------------------------------------------------
// ybd_queue
// Short FIFO of classified bytes between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module ybd_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire ybd_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output ybd_pkg::t_cmd      o_cmd,
    output logic               o_full,
    output logic               o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    ybd_pkg::t_cmd r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr, n_wr;
    logic [PTR_W-1:0] r_rd, n_rd;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd];

    always_comb begin
        n_wr = r_wr;
        n_rd = r_rd;
        n_count = r_count;
        if (i_push) begin
            n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (i_pop) begin
            n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr <= '0;
            r_rd <= '0;
            r_count <= '0;
        end else begin
            r_wr <= n_wr;
            r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ybd_back.sv =====
// ----------------------------------------------------------------------------
// ybd_back
// Holds the decode state, executes queued bytes and registers the result.
// ----------------------------------------------------------------------------
`default_nettype none

module ybd_back (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic [ybd_pkg::SIZE_W-1:0]   i_expected_size,
    input  wire logic [ybd_pkg::LINE_W-1:0]   i_expected_line_length,
    input  wire ybd_pkg::t_cmd                i_cmd,
    input  wire logic                         i_q_empty,
    output logic                              o_pop,
    yenc_out_if.source                        o_out_ch
);

    logic                        r_als, n_als;
    logic                        r_esc, n_esc;
    logic [ybd_pkg::LINE_W-1:0]  r_line, n_line;
    logic [ybd_pkg::SIZE_W-1:0]  r_cnt, n_cnt;
    ybd_pkg::t_status            r_fin, n_fin;
    logic                        r_ovalid, n_ovalid;
    ybd_pkg::t_result            r_out, n_out;

    logic                        w_emit;
    logic [7:0]                  w_val;

    assign o_pop = !i_q_empty && (!r_ovalid || o_out_ch.ready);

    always_comb begin
        n_als = i_cmd.first ? 1'b1 : r_als;
        n_esc = i_cmd.first ? 1'b0 : r_esc;
        n_line = i_cmd.first ? '0 : r_line;
        n_cnt = i_cmd.first ? '0 : r_cnt;
        n_fin = i_cmd.first ? ybd_pkg::ST_RUNNING : r_fin;
        w_emit = 1'b0;
        w_val = i_cmd.plain_val;
        n_out.out_byte = 8'd0;
        n_out.out_valid = 1'b0;

        if (n_fin == ybd_pkg::ST_RUNNING) begin
            if (n_esc) begin
                n_esc = 1'b0;
                if (n_als && i_cmd.is_y) begin
                    n_fin = (n_cnt == i_expected_size) ? ybd_pkg::ST_END_OK
                                                       : ybd_pkg::ST_SIZE_BAD;
                end else begin
                    w_emit = 1'b1;
                    w_val = i_cmd.esc_val;
                end
            end else begin
                case (i_cmd.cls)
                    ybd_pkg::CLS_CR: begin
                        if (n_line != i_expected_line_length && n_cnt != i_expected_size) begin
                            n_fin = ybd_pkg::ST_BAD_LINE;
                        end
                    end
                    ybd_pkg::CLS_LF: begin
                        n_als = 1'b1;
                        n_line = '0;
                    end
                    ybd_pkg::CLS_ESC: n_esc = 1'b1;
                    default:          w_emit = 1'b1;
                endcase
            end

            if (w_emit) begin
                if (n_cnt >= i_expected_size) begin
                    n_fin = ybd_pkg::ST_OVERFLOW;
                end else begin
                    n_out.out_byte = w_val;
                    n_out.out_valid = 1'b1;
                    n_cnt = n_cnt + 1'b1;
                    if (n_line < ybd_pkg::LINE_MAX) begin
                        n_line = n_line + 1'b1;
                    end
                    n_als = 1'b0;
                end
            end

            if (i_cmd.last && n_fin == ybd_pkg::ST_RUNNING) begin
                n_fin = ybd_pkg::ST_TRUNC;
            end
        end
        n_out.status = n_fin;
    end

    always_comb begin
        if (o_pop) begin
            n_ovalid = 1'b1;
        end else if (o_out_ch.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_als <= 1'b1;
            r_esc <= 1'b0;
            r_line <= '0;
            r_cnt <= '0;
            r_fin <= ybd_pkg::ST_RUNNING;
            r_ovalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            if (o_pop) begin
                r_als <= n_als;
                r_esc <= n_esc;
                r_line <= n_line;
                r_cnt <= n_cnt;
                r_fin <= n_fin;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_out_ch.valid     = r_ovalid;
    assign o_out_ch.out_byte  = r_out.out_byte;
    assign o_out_ch.out_valid = r_out.out_valid;
    assign o_out_ch.status    = r_out.status;

endmodule

`default_nettype wire

// ===== rtl/yenc_body_decoder.sv =====
// ----------------------------------------------------------------------------
// yenc_body_decoder
// yEnc body decoder: one raw byte in, one result (byte, flag, status) out.
//
//   Channel   Dir  Payload                                   Handshake
//   i_in_ch   in   in_byte, first_of_message, last_of_data   valid/ready
//   o_out_ch  out  out_byte, out_valid, status               valid/ready
//   i_cfg_*   in   index 0 expected_size, 1 line length      write enable
//
// One byte per cycle sustained while the output is ready; the back state is updated on each pop.
// After the input transaction the byte is written to the queue; its result is then
// registered in the output register.
// The queue holds QUEUE_DEPTH bytes; input ready drops only when it is full.
// Reset is synchronous; it clears decode state, queue and output valid.
// ----------------------------------------------------------------------------
`default_nettype none

module yenc_body_decoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    yenc_in_if.sink                              i_in_ch,
    yenc_out_if.source                           o_out_ch,
    input  wire logic                            i_cfg_we,
    input  wire logic [ybd_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire logic [ybd_pkg::SIZE_W-1:0]      i_cfg_data
);

    logic [ybd_pkg::SIZE_W-1:0] r_expected_size;
    logic [ybd_pkg::LINE_W-1:0] r_expected_line_length;

    ybd_pkg::t_cmd w_push_cmd;
    ybd_pkg::t_cmd w_pop_cmd;
    logic          w_push;
    logic          w_pop;
    logic          w_q_full;
    logic          w_q_empty;
    logic          w_byte_status_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expected_size <= '0;
            r_expected_line_length <= ybd_pkg::LINE_LEN_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ybd_pkg::CFG_EXPECTED_SIZE: r_expected_size <= i_cfg_data;
                ybd_pkg::CFG_EXPECTED_LINE_LENGTH:
                    r_expected_line_length <= i_cfg_data[ybd_pkg::LINE_W-1:0];
                default: ;
            endcase
        end
    end

    ybd_front u_front (
        .i_in_ch  (i_in_ch),
        .i_q_full (w_q_full),
        .o_cmd    (w_push_cmd),
        .o_push   (w_push)
    );

    ybd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_pop_cmd),
        .o_full  (w_q_full),
        .o_empty (w_q_empty)
    );

    ybd_back u_back (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_expected_size        (r_expected_size),
        .i_expected_line_length (r_expected_line_length),
        .i_cmd                  (w_pop_cmd),
        .i_q_empty              (w_q_empty),
        .o_pop                  (w_pop),
        .o_out_ch               (o_out_ch)
    );

    assign w_byte_status_ok = (o_out_ch.status == ybd_pkg::ST_RUNNING) ||
                              (o_out_ch.status == ybd_pkg::ST_TRUNC);

`include "yenc_body_decoder_assert.svh"

    `YBD_ASSERT_SAME(a_pop_not_empty, i_clk, i_rst_n, w_pop, !w_q_empty)
    `YBD_ASSERT_SAME(a_full_not_empty, i_clk, i_rst_n, w_q_full, !w_q_empty)
    `YBD_ASSERT_SAME(a_byte_only_running, i_clk, i_rst_n, o_out_ch.valid && o_out_ch.out_valid, w_byte_status_ok)
    `YBD_ASSERT_NEXT(a_pop_gives_result, i_clk, i_rst_n, w_pop, o_out_ch.valid)

endmodule

`default_nettype wire
